[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each expects clk in scope; TIRD_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define TIRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TIRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/tird_pkg.sv]
`default_nettype none
package tird_pkg;

  // Tile geometry
  localparam int TILE_SIZE  = 64;
  localparam int TILE_SHIFT = 6;
  localparam int TILE_CNT_W = 11;  // tile count per axis, up to 1024
  localparam int EXT_W      = 7;   // tile extent, 1..64
  localparam int PLANE_W    = 13;  // plane size and position, up to 4096
  localparam int MAX_PLANES = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_LEVEL_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_LEVEL_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BPP          = 2'd2;
  localparam logic [1:0] CFG_MODE         = 2'd3;

  // Opcodes with a 16-bit count
  localparam logic [7:0] OP_LONG_REPEAT  = 8'd127;
  localparam logic [7:0] OP_LONG_LITERAL = 8'd128;

  localparam logic MODE_RAW = 1'b0;

  typedef enum logic [4:0] {
    PH_OPCODE       = 5'b00001,
    PH_LONG_HI      = 5'b00010,
    PH_LONG_LO      = 5'b00100,
    PH_REPEAT_VALUE = 5'b01000,
    PH_LITERAL      = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  plane_index;
    logic [9:0]  tile_row;
    logic [9:0]  tile_column;
    logic [11:0] start_offset;
    logic [12:0] run_length;
    logic [7:0]  value;
    logic        plane_done;
    logic        tile_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [15:0] wdata;
  } cfg_item_t;

  // Geometry of the current plane, as seen by the decoder
  typedef struct packed {
    logic [PLANE_W-1:0] avail;  // elements left in the plane (at least one)
    logic               last_col;
    logic               last_row;
    logic               last_plane;
  } geom_t;

endpackage
`default_nettype wire

[hw/rtl/tird_if.sv]
`default_nettype none
// Compressed byte input channel
interface tird_in_if import tird_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Run descriptor output channel
interface tird_out_if import tird_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Register write channel
interface tird_cfg_if import tird_pkg::*;;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/tird_geom.sv]
`default_nettype none
module tird_geom import tird_pkg::*; (
  input  wire logic [15:0]        img_width,
  input  wire logic [15:0]        img_height,
  input  wire logic [2:0]         bytes_per_pixel,
  input  wire logic [9:0]         tile_col,
  input  wire logic [9:0]         tile_row,
  input  wire logic [1:0]         plane,
  input  wire logic [PLANE_W-1:0] position,
  output geom_t                   geom
);

  logic [15:0]           w_eff, h_eff;
  logic [16:0]           w_sum, h_sum;
  logic [TILE_CNT_W-1:0] n_cols, n_rows;
  logic [TILE_CNT_W-1:0] col_inc, row_inc;
  logic [EXT_W-1:0]      ext_w, ext_h;
  logic [2*EXT_W-1:0]    size_full;
  logic [PLANE_W-1:0]    plane_size;
  logic [2:0]            n_planes;

  // Tile counts; a zero dimension counts as one pixel
  assign w_eff  = (img_width == 16'd0) ? 16'd1 : img_width;
  assign h_eff  = (img_height == 16'd0) ? 16'd1 : img_height;
  assign w_sum  = {1'b0, w_eff} + 17'(TILE_SIZE - 1);
  assign h_sum  = {1'b0, h_eff} + 17'(TILE_SIZE - 1);
  assign n_cols = w_sum[16:TILE_SHIFT];
  assign n_rows = h_sum[16:TILE_SHIFT];

  assign col_inc = {1'b0, tile_col} + TILE_CNT_W'(1);
  assign row_inc = {1'b0, tile_row} + TILE_CNT_W'(1);
  assign geom.last_col = (col_inc >= n_cols);
  assign geom.last_row = (row_inc >= n_rows);

  // Edge tiles take the remainder of the dimension
  always_comb begin
    ext_w = EXT_W'(TILE_SIZE);
    ext_h = EXT_W'(TILE_SIZE);
    if (geom.last_col && (w_eff[TILE_SHIFT-1:0] != '0)) begin
      ext_w = {1'b0, w_eff[TILE_SHIFT-1:0]};
    end
    if (geom.last_row && (h_eff[TILE_SHIFT-1:0] != '0)) begin
      ext_h = {1'b0, h_eff[TILE_SHIFT-1:0]};
    end
  end

  assign size_full  = ext_w * ext_h;
  assign plane_size = size_full[PLANE_W-1:0];

  // A position past the plane end still lets one element through
  assign geom.avail = (position < plane_size) ? (plane_size - position) : PLANE_W'(1);

  // Plane count clamped to 1..4
  always_comb begin
    n_planes = bytes_per_pixel;
    if (bytes_per_pixel == 3'd0) begin
      n_planes = 3'd1;
    end else if (bytes_per_pixel > 3'(MAX_PLANES)) begin
      n_planes = 3'(MAX_PLANES);
    end
  end

  assign geom.last_plane = (({1'b0, plane} + 3'd1) >= n_planes);

endmodule
`default_nettype wire

[hw/rtl/tiled_image_rle_decoder_core.sv]
// Tiled image RLE decoder: takes one compressed byte per transaction on in_if and emits
// one run descriptor on out_if for every byte that writes plane elements (literal
// bytes, repeat values and, in raw mode, every byte); opcode and count bytes give no
// descriptor. Throughput is one byte per cycle while out_if is not stalled: a byte is
// registered, decoded against the phase, run and tile state in a single pass, and the
// descriptor lands in the output register. A stalled out_if backs up into in_if.ready
// through the one-byte input register. Registers (width, height, bytes per pixel, mode)
// must be written on cfg_if only while no byte is in flight; the block itself does not
// enforce this. cfg_if.ready is always high.
`default_nettype none
`include "assert_macros.svh"
module tiled_image_rle_decoder_core import tird_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  tird_in_if.sink    in_if,
  tird_out_if.source out_if,
  tird_cfg_if.sink   cfg_if
);

  // Configuration
  logic [15:0] width_r, height_r;
  logic [2:0]  bpp_r;
  logic        mode_r;

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;

  // Decode and position state
  phase_t             phase_r, phase_nxt;
  logic               lit_r, lit_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [7:0]         hi_r, hi_nxt;
  logic [PLANE_W-1:0] pos_r, pos_nxt;
  logic [1:0]         plane_r, plane_nxt;
  logic [9:0]         row_r, row_nxt;
  logic [9:0]         col_r, col_nxt;

  // Output register
  logic      out_vld_r;
  out_item_t out_r;

  logic               out_free, s1_adv, emit;
  logic [15:0]        want, rem_dec;
  logic [PLANE_W-1:0] len;
  logic               pdone;
  geom_t              geom;

  // Handshakes
  assign out_free     = !out_vld_r || out_if.ready;
  assign s1_adv       = s1_vld_r && out_free;
  assign in_if.ready  = !s1_vld_r || out_free;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd64;
      height_r <= 16'd64;
      bpp_r    <= 3'd3;
      mode_r   <= 1'b1;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.reg_index)
        CFG_LEVEL_WIDTH:  width_r  <= cfg_if.data.wdata;
        CFG_LEVEL_HEIGHT: height_r <= cfg_if.data.wdata;
        CFG_BPP:          bpp_r    <= cfg_if.data.wdata[2:0];
        CFG_MODE:         mode_r   <= cfg_if.data.wdata[0];
        default:          ;
      endcase
    end
  end

  // Capture the incoming byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_byte_r <= in_if.data.in_byte;
    end
  end

  tird_geom u_geom (
    .img_width       (width_r),
    .img_height      (height_r),
    .bytes_per_pixel (bpp_r),
    .tile_col        (col_r),
    .tile_row        (row_r),
    .plane           (plane_r),
    .position        (pos_r),
    .geom            (geom)
  );

  // Requested run length: the repeat count for a repeat value, else one
  always_comb begin
    want = 16'd1;
    if ((mode_r != MODE_RAW) && (phase_r == PH_REPEAT_VALUE)) begin
      want = rem_r;
    end
  end

  // Clip at the plane end
  assign len   = (want < {3'd0, geom.avail}) ? want[PLANE_W-1:0] : geom.avail;
  assign pdone = (len == geom.avail);

  // Opcode decode
  always_comb begin
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    rem_nxt   = rem_r;
    hi_nxt    = hi_r;
    emit      = 1'b0;
    rem_dec   = rem_r - 16'd1;
    if (mode_r == MODE_RAW) begin
      phase_nxt = PH_OPCODE;
      emit      = 1'b1;
    end else begin
      case (phase_r)
        PH_OPCODE: begin
          if (s1_byte_r < OP_LONG_REPEAT) begin
            lit_nxt   = 1'b0;
            rem_nxt   = {8'd0, s1_byte_r} + 16'd1;
            phase_nxt = PH_REPEAT_VALUE;
          end else if (s1_byte_r == OP_LONG_REPEAT) begin
            lit_nxt   = 1'b0;
            phase_nxt = PH_LONG_HI;
          end else if (s1_byte_r == OP_LONG_LITERAL) begin
            lit_nxt   = 1'b1;
            phase_nxt = PH_LONG_HI;
          end else begin
            lit_nxt   = 1'b1;
            rem_nxt   = 16'd256 - {8'd0, s1_byte_r};
            phase_nxt = PH_LITERAL;
          end
        end
        PH_LONG_HI: begin
          hi_nxt    = s1_byte_r;
          phase_nxt = PH_LONG_LO;
        end
        PH_LONG_LO: begin
          rem_nxt = {hi_r, s1_byte_r};
          if (!lit_r) begin
            phase_nxt = PH_REPEAT_VALUE;
          end else if ({hi_r, s1_byte_r} != 16'd0) begin
            phase_nxt = PH_LITERAL;
          end else begin
            phase_nxt = PH_OPCODE;
          end
        end
        PH_REPEAT_VALUE: begin
          phase_nxt = PH_OPCODE;
          if (rem_r != 16'd0) begin
            emit    = 1'b1;
            rem_nxt = 16'd0;
          end
        end
        PH_LITERAL: begin
          if (rem_r == 16'd0) begin
            phase_nxt = PH_OPCODE;
          end else begin
            emit    = 1'b1;
            rem_nxt = rem_dec;
            // A run cut by the plane end leaves its bytes to the next opcode
            if (pdone || (rem_dec == 16'd0)) begin
              rem_nxt   = 16'd0;
              phase_nxt = PH_OPCODE;
            end
          end
        end
        default: begin
          phase_nxt = PH_OPCODE;
        end
      endcase
    end
  end

  // Advance position, plane and tile
  always_comb begin
    pos_nxt   = pos_r;
    plane_nxt = plane_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (emit) begin
      if (pdone) begin
        pos_nxt = '0;
        if (geom.last_plane) begin
          plane_nxt = '0;
          if (geom.last_col) begin
            col_nxt = '0;
            row_nxt = geom.last_row ? 10'd0 : row_r + 10'd1;
          end else begin
            col_nxt = col_r + 10'd1;
          end
        end else begin
          plane_nxt = plane_r + 2'd1;
        end
      end else begin
        pos_nxt = pos_r + len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      lit_r   <= 1'b0;
      rem_r   <= '0;
      hi_r    <= '0;
      pos_r   <= '0;
      plane_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      rem_r   <= rem_nxt;
      hi_r    <= hi_nxt;
      pos_r   <= pos_nxt;
      plane_r <= plane_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // Load the descriptor, or drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= emit;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_r.plane_index  <= plane_r;
      out_r.tile_row     <= row_r;
      out_r.tile_column  <= col_r;
      out_r.start_offset <= pos_r[11:0];
      out_r.run_length   <= len;
      out_r.value        <= s1_byte_r;
      out_r.plane_done   <= pdone;
      out_r.tile_done    <= pdone && geom.last_plane;
    end
  end

  `TIRD_ASSERT(a_run_nonzero, out_vld_r |-> (out_r.run_length != 13'd0), "empty run emitted")
  `TIRD_ASSERT(a_tile_implies_plane, (out_vld_r && out_r.tile_done) |-> out_r.plane_done,
               "tile done without plane done")
  `TIRD_ASSERT(a_pos_in_plane, pos_r[PLANE_W-1] == 1'b0, "plane position past 4095")
  `TIRD_ASSERT(a_raw_to_opcode, (s1_adv && (mode_r == MODE_RAW)) |=> (phase_r == PH_OPCODE),
               "raw byte left decoder in a run")

endmodule
`default_nettype wire

[sim/testbench.sv]
module testbench;
  import tird_pkg::*;

  localparam int         REPEAT_OP_MAX    = 126;
  localparam logic       MODE_RLE         = 1'b1;
  localparam int         SETTLE_CYCLES    = 8;
  localparam int         LONG_HOLD_CYCLES = 400;
  localparam int         RANDOM_PHASES    = 8;
  localparam int         PHASE_BYTES      = 190;
  localparam int         PACE_NONE        = 0;
  localparam int         PACE_FULL        = 1;
  localparam int         PACE_SPARSE      = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tird_in_if  in_if();
  tird_out_if out_if();
  tird_cfg_if cfg_if();

  tiled_image_rle_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stream bookkeeping
  logic [7:0]   pending_bytes[$];
  out_item_t    expected_runs[$];
  int unsigned  bytes_queued = 0;
  int unsigned  bytes_accepted = 0;
  int unsigned  runs_checked = 0;
  int unsigned  planes_seen = 0;
  int unsigned  tiles_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  settings_used = 0;
  int           in_pace = PACE_NONE;
  int           out_pace = PACE_NONE;
  int           in_wait = 0;
  int           out_wait = 0;
  bit           start_hold = 1'b0;
  logic         hold_active = 1'b0;
  out_item_t    predicted_run;
  out_item_t    got_run;
  out_item_t    want_run;

  // Decoder shadow: registers
  int unsigned  cfg_width = 64;
  int unsigned  cfg_height = 64;
  int unsigned  cfg_bpp = 3;
  logic         cfg_mode = MODE_RLE;

  // Decoder shadow: run and tile position
  phase_t       dec_phase = PH_OPCODE;
  bit           lit_run = 1'b0;
  int unsigned  run_left = 0;
  int unsigned  count_hi = 0;
  int unsigned  plane_pos = 0;
  int unsigned  plane_sel = 0;
  int unsigned  tile_r = 0;
  int unsigned  tile_c = 0;

  function automatic int unsigned tiles_along(int unsigned len);
    int unsigned l;
    l = (len == 0) ? 1 : len;
    return (l + TILE_SIZE - 1) / TILE_SIZE;
  endfunction

  function automatic int unsigned extent(int unsigned len, int unsigned idx);
    int unsigned l, n;
    l = (len == 0) ? 1 : len;
    n = tiles_along(l);
    if (idx + 1 >= n) return l - (n - 1) * TILE_SIZE;
    return TILE_SIZE;
  endfunction

  // Write up to want elements, clip at the plane end and advance plane and tile
  function automatic out_item_t emit_span(int unsigned want, logic [7:0] val);
    out_item_t   r;
    int unsigned size, avail, len, planes;
    size   = extent(cfg_width, tile_c) * extent(cfg_height, tile_r);
    avail  = (plane_pos < size) ? size - plane_pos : 1;
    len    = (want < avail) ? want : avail;
    planes = (cfg_bpp == 0) ? 1 : (cfg_bpp > 4) ? 4 : cfg_bpp;
    r.plane_index  = 2'(plane_sel);
    r.tile_row     = 10'(tile_r);
    r.tile_column  = 10'(tile_c);
    r.start_offset = 12'(plane_pos);
    r.run_length   = 13'(len);
    r.value        = val;
    r.plane_done   = (len == avail);
    r.tile_done    = 1'b0;
    if (r.plane_done) begin
      plane_pos = 0;
      if (plane_sel + 1 >= planes) begin
        r.tile_done = 1'b1;
        plane_sel = 0;
        if (tile_c + 1 >= tiles_along(cfg_width)) begin
          tile_c = 0;
          tile_r = (tile_r + 1 >= tiles_along(cfg_height)) ? 0 : (tile_r + 1) & 'h3FF;
        end else begin
          tile_c = (tile_c + 1) & 'h3FF;
        end
      end else begin
        plane_sel = (plane_sel + 1) & 3;
      end
    end else begin
      plane_pos = (plane_pos + len) & 'h1FFF;
    end
    return r;
  endfunction

  // Advance the shadow decoder by one byte; return 1 when a run descriptor results
  function automatic bit decode_byte(input logic [7:0] b, output out_item_t r);
    int unsigned count;
    bit          emitted;
    emitted = 1'b0;
    r = '0;
    if (cfg_mode == MODE_RAW) begin
      dec_phase = PH_OPCODE;
      r = emit_span(1, b);
      emitted = 1'b1;
    end else begin
      case (dec_phase)
        PH_OPCODE: begin
          if (b <= REPEAT_OP_MAX) begin
            lit_run = 1'b0;
            run_left = b + 1;
            dec_phase = PH_REPEAT_VALUE;
          end else if (b == OP_LONG_REPEAT) begin
            lit_run = 1'b0;
            dec_phase = PH_LONG_HI;
          end else if (b == OP_LONG_LITERAL) begin
            lit_run = 1'b1;
            dec_phase = PH_LONG_HI;
          end else begin
            lit_run = 1'b1;
            run_left = 256 - b;
            dec_phase = PH_LITERAL;
          end
        end
        PH_LONG_HI: begin
          count_hi = b;
          dec_phase = PH_LONG_LO;
        end
        PH_LONG_LO: begin
          count = (count_hi << 8) | b;
          run_left = count;
          if (lit_run) dec_phase = (count != 0) ? PH_LITERAL : PH_OPCODE;
          else dec_phase = PH_REPEAT_VALUE;
        end
        PH_REPEAT_VALUE: begin
          dec_phase = PH_OPCODE;
          if (run_left != 0) begin
            r = emit_span(run_left, b);
            run_left = 0;
            emitted = 1'b1;
          end
        end
        PH_LITERAL: begin
          if (run_left == 0) begin
            dec_phase = PH_OPCODE;
          end else begin
            run_left = (run_left - 1) & 'hFFFF;
            r = emit_span(1, b);
            emitted = 1'b1;
            if (r.plane_done || run_left == 0) begin
              run_left = 0;
              dec_phase = PH_OPCODE;
            end
          end
        end
        default: dec_phase = PH_OPCODE;
      endcase
    end
    return emitted;
  endfunction

  function automatic int draw_wait(int pace);
    if (pace == PACE_NONE) return 0;
    if (pace == PACE_FULL) return $urandom_range(0, 16);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Stream building
  function automatic void queue_byte(logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void push_repeat(int n, logic [7:0] v);
    queue_byte(8'(n - 1));
    queue_byte(v);
  endfunction

  function automatic void push_literal_op(int n);
    queue_byte(8'(256 - n));
  endfunction

  function automatic void push_long(logic [7:0] op, int unsigned count);
    queue_byte(op);
    queue_byte(8'(count >> 8));
    queue_byte(8'(count));
  endfunction

  // Mostly well-formed sequences with random content, some noise and truncation
  function automatic void fill_random(int n);
    int unsigned base, kind, cnt;
    base = bytes_queued;
    while (bytes_queued - base < n) begin
      if (cfg_mode == MODE_RAW) begin
        queue_byte(8'($urandom));
      end else begin
        kind = $urandom_range(0, 19);
        if (kind <= 5) begin
          push_repeat($urandom_range(1, 127), 8'($urandom));
        end else if (kind <= 10) begin
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 12);
          push_literal_op(cnt);
          repeat (cnt) queue_byte(8'($urandom));
        end else if (kind <= 12) begin
          cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
          push_long(OP_LONG_REPEAT, cnt);
          queue_byte(8'($urandom));
        end else if (kind <= 14) begin
          cnt = $urandom_range(0, 24);
          push_long(OP_LONG_LITERAL, cnt);
          repeat (cnt) queue_byte(8'($urandom));
        end else if (kind == 15) begin
          push_long(OP_LONG_LITERAL, $urandom_range(0, 65535));
          repeat ($urandom_range(0, 30)) queue_byte(8'($urandom));
        end else if (kind <= 17) begin
          queue_byte(8'($urandom));
        end else begin
          queue_byte(($urandom_range(0, 1) == 0) ? OP_LONG_REPEAT : OP_LONG_LITERAL);
          if ($urandom_range(0, 1) == 0) queue_byte(8'($urandom));
        end
      end
    end
  endfunction

  // Register writes; call from code that runs in step with posedge clk
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_if.data  <= '{reg_index: idx, wdata: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_LEVEL_WIDTH:  cfg_width = val;
      CFG_LEVEL_HEIGHT: cfg_height = val;
      CFG_BPP:          cfg_bpp = val[2:0];
      CFG_MODE:         cfg_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned bpp, logic mode);
    write_reg(CFG_LEVEL_WIDTH, 16'(w));
    write_reg(CFG_LEVEL_HEIGHT, 16'(h));
    write_reg(CFG_BPP, 16'(bpp));
    write_reg(CFG_MODE, 16'(mode));
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Wait until every byte is in and every run is out, then let opcodes drain
  task automatic drain();
    while (pending_bytes.size() != 0 || in_if.valid || expected_runs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte driver: present queued bytes, predict each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        bytes_accepted++;
        if (decode_byte(in_if.data.in_byte, predicted_run))
          expected_runs.push_back(predicted_run);
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_if.data  <= '{in_byte: pending_bytes.pop_front()};
          in_if.valid <= 1'b1;
          in_wait = draw_wait(in_pace);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Run monitor: compare each accepted descriptor with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_run = out_if.data;
        runs_checked++;
        if (got_run.plane_done) planes_seen++;
        if (got_run.tile_done) tiles_seen++;
        if (expected_runs.size() == 0) begin
          $error("run descriptor with no prediction pending: value %0d offset %0d",
                 got_run.value, got_run.start_offset);
          mismatches++;
        end else begin
          want_run = expected_runs.pop_front();
          check_field("plane_index", want_run.plane_index, got_run.plane_index);
          check_field("tile_row", want_run.tile_row, got_run.tile_row);
          check_field("tile_column", want_run.tile_column, got_run.tile_column);
          check_field("start_offset", want_run.start_offset, got_run.start_offset);
          check_field("run_length", want_run.run_length, got_run.run_length);
          check_field("value", want_run.value, got_run.value);
          check_field("plane_done", want_run.plane_done, got_run.plane_done);
          check_field("tile_done", want_run.tile_done, got_run.tile_done);
        end
        out_wait = draw_wait(out_pace);
      end
      if (hold_active) begin
        out_if.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering bytes
  initial begin
    wait (start_hold);
    repeat (20) @(posedge clk);
    hold_active <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  // Stimulus sequence
  initial begin
    int w, h;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: extreme opcodes, plane end inside a long repeat, zero counts,
    // and a literal run left open into the raw phase
    push_repeat(1, 8'h00);
    push_repeat(127, 8'hFF);
    push_literal_op(1);
    queue_byte(8'hA5);
    push_long(OP_LONG_REPEAT, 4096);
    queue_byte(8'h5A);
    push_long(OP_LONG_LITERAL, 0);
    push_long(OP_LONG_REPEAT, 0);
    queue_byte(8'h33);
    push_literal_op(56);
    queue_byte(8'h77);
    drain();

    // Raw bytes with zero sizes: every byte fills a one-element tile
    configure(0, 0, 0, MODE_RAW);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h3C);
    drain();

    // Literal run cut at the plane end; the leftover bytes become an opcode and its repeat value
    configure(1, 1, 2, MODE_RLE);
    push_literal_op(3);
    queue_byte(8'h11);
    queue_byte(8'h22);
    queue_byte(8'h44);
    drain();

    // Random settings, the extremes first
    for (int i = 0; i < RANDOM_PHASES; i++) begin
      if (i == 0) begin
        configure(65535, 65535, 7, MODE_RLE);
      end else if (i == 1) begin
        configure(1, 1, 1, MODE_RLE);
      end else if (i == 2) begin
        configure($urandom_range(1, 150), $urandom_range(1, 150), $urandom_range(0, 7),
                  MODE_RAW);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 150);
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 150);
        configure(w, h, $urandom_range(0, 7),
                  ($urandom_range(0, 4) == 0) ? MODE_RAW : MODE_RLE);
      end
      in_pace  = (i == 0) ? PACE_NONE : $urandom_range(PACE_NONE, PACE_SPARSE);
      out_pace = (i == 0) ? PACE_NONE : $urandom_range(PACE_NONE, PACE_SPARSE);
      fill_random(PHASE_BYTES);
      if (i == 0) start_hold = 1'b1;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("testbench: %0d bytes decoded under %0d register settings, %0d runs compared",
             bytes_accepted, settings_used + 1, runs_checked);
    $display("testbench: %0d planes and %0d tiles completed, %0d mismatches",
             planes_seen, tiles_seen, mismatches);
    if (mismatches == 0 && expected_runs.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
